### rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the i2c master bit sequencer
// no dependencies; imported by i2cms_step, i2cms_out_reg and the top level

package i2cms_pkg;

	localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd101;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [16:0] {
		ST_IDLE        = 17'b00000000000000001,
		ST_START       = 17'b00000000000000010,
		ST_STOP_LOW    = 17'b00000000000000100,
		ST_STOP_RISE   = 17'b00000000000001000,
		ST_STOP_END    = 17'b00000000000010000,
		ST_ADDR_SET    = 17'b00000000000100000,
		ST_ADDR_RISE   = 17'b00000000001000000,
		ST_ADDR_SAMPLE = 17'b00000000010000000,
		ST_AACK_SET    = 17'b00000000100000000,
		ST_AACK_RISE   = 17'b00000001000000000,
		ST_AACK_SAMPLE = 17'b00000010000000000,
		ST_DATA_SET    = 17'b00000100000000000,
		ST_DATA_RISE   = 17'b00001000000000000,
		ST_DATA_SAMPLE = 17'b00010000000000000,
		ST_DACK_SET    = 17'b00100000000000000,
		ST_DACK_RISE   = 17'b01000000000000000,
		ST_DACK_SAMPLE = 17'b10000000000000000
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] bit_cnt;
		logic [7:0] shift;
		logic [7:0] rcv;
		logic [7:0] bytes_done;
		logic [7:0] bytes_wanted;
		logic       read_mode;
		logic [7:0] stretch_cnt;
		logic       scl;
		logic       sda;
		logic       nack;
	} seq_state_t;

	localparam seq_state_t STATE_RESET = '{
		phase: ST_IDLE, bit_cnt: 3'd0, shift: 8'd0, rcv: 8'd0, bytes_done: 8'd0,
		bytes_wanted: 8'd0, read_mode: 1'b0, stretch_cnt: 8'd0, scl: 1'b1,
		sda: 1'b1, nack: 1'b0
	};

	typedef struct packed {
		logic       sda_in;
		logic       scl_in;
		logic [7:0] wr_data;
		logic [7:0] byte_count;
		logic [6:0] target_address;
		logic [1:0] kind;
	} item_t;

	// packed so that scl_out lands in bit 0
	typedef struct packed {
		logic [7:0] byte_index;
		logic       byte_taken;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic [7:0] transferred;
		logic       nacked;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### rtl/i2cms_step.sv
`timescale 1ns / 1ps
// one tick of the bus sequencer: next state and result from current state and item
// depends on i2cms_pkg

module i2cms_step (
	input  i2cms_pkg::seq_state_t st,
	input  i2cms_pkg::item_t      item,
	input  logic [7:0]            stretch_limit,
	output i2cms_pkg::seq_state_t st_nxt,
	output i2cms_pkg::result_t    res
);
	import i2cms_pkg::*;

	logic       proceed;
	logic       done, rdv, taken;
	logic [7:0] rdd;
	logic [7:0] shift_cur;
	logic [7:0] rcv_nxt;
	logic [7:0] bytes_inc;
	logic       busy;

	assign proceed   = item.scl_in || (st.stretch_cnt == stretch_limit);
	assign rcv_nxt   = {st.rcv[6:0], item.sda_in};
	assign bytes_inc = st.bytes_done + 8'd1;
	assign shift_cur = (st.bit_cnt == 3'd0) ? item.wr_data : st.shift;

	always_comb begin
		st_nxt = st;
		done   = 1'b0;
		rdv    = 1'b0;
		taken  = 1'b0;
		rdd    = 8'd0;
		case (st.phase)
			ST_ADDR_SET: begin
				st_nxt.sda   = st.shift[7];
				st_nxt.phase = ST_ADDR_RISE;
			end
			ST_AACK_SET: begin
				st_nxt.sda   = 1'b1;
				st_nxt.phase = ST_AACK_RISE;
			end
			ST_DATA_SET: begin
				if (st.read_mode) begin
					st_nxt.sda = 1'b1;
				end else begin
					st_nxt.shift = shift_cur;
					taken        = (st.bit_cnt == 3'd0);
					st_nxt.sda   = shift_cur[7];
				end
				st_nxt.phase = ST_DATA_RISE;
			end
			ST_DACK_SET: begin
				// master acks every read byte but the last
				st_nxt.sda   = st.read_mode ? (st.bytes_done == st.bytes_wanted) : 1'b1;
				st_nxt.phase = ST_DACK_RISE;
			end
			ST_ADDR_RISE, ST_AACK_RISE, ST_DATA_RISE, ST_DACK_RISE: begin
				st_nxt.scl         = 1'b1;
				st_nxt.stretch_cnt = 8'd0;
				case (st.phase)
					ST_ADDR_RISE: st_nxt.phase = ST_ADDR_SAMPLE;
					ST_AACK_RISE: st_nxt.phase = ST_AACK_SAMPLE;
					ST_DATA_RISE: st_nxt.phase = ST_DATA_SAMPLE;
					default:      st_nxt.phase = ST_DACK_SAMPLE;
				endcase
			end
			ST_ADDR_SAMPLE, ST_DATA_SAMPLE: begin
				if (!proceed) begin
					st_nxt.stretch_cnt = st.stretch_cnt + 8'd1;
				end else begin
					st_nxt.scl   = 1'b0;
					st_nxt.shift = {st.shift[6:0], 1'b0};
					st_nxt.rcv   = rcv_nxt;
					if (st.bit_cnt == 3'd7) begin
						st_nxt.bit_cnt = 3'd0;
						if (st.phase == ST_ADDR_SAMPLE) begin
							st_nxt.phase = ST_AACK_SET;
						end else begin
							st_nxt.phase = ST_DACK_SET;
							if (st.read_mode) begin
								rdv               = 1'b1;
								rdd               = rcv_nxt;
								st_nxt.bytes_done = bytes_inc;
							end
						end
					end else begin
						st_nxt.bit_cnt = st.bit_cnt + 3'd1;
						st_nxt.phase   = (st.phase == ST_ADDR_SAMPLE) ? ST_ADDR_SET : ST_DATA_SET;
					end
				end
			end
			ST_AACK_SAMPLE: begin
				if (!proceed) begin
					st_nxt.stretch_cnt = st.stretch_cnt + 8'd1;
				end else begin
					st_nxt.scl = 1'b0;
					if (item.sda_in) begin
						st_nxt.nack  = 1'b1;
						st_nxt.phase = ST_STOP_LOW;
					end else if (st.bytes_wanted == 8'd0) begin
						st_nxt.phase = ST_STOP_LOW;
					end else begin
						st_nxt.phase = ST_DATA_SET;
					end
				end
			end
			ST_DACK_SAMPLE: begin
				if (!proceed) begin
					st_nxt.stretch_cnt = st.stretch_cnt + 8'd1;
				end else begin
					st_nxt.scl = 1'b0;
					if (st.read_mode) begin
						st_nxt.phase = (st.bytes_done == st.bytes_wanted) ? ST_STOP_LOW
							: ST_DATA_SET;
					end else if (item.sda_in) begin
						st_nxt.nack  = 1'b1;
						st_nxt.phase = ST_STOP_LOW;
					end else begin
						st_nxt.bytes_done = bytes_inc;
						st_nxt.phase      = (bytes_inc == st.bytes_wanted) ? ST_STOP_LOW
							: ST_DATA_SET;
					end
				end
			end
			ST_START: begin
				st_nxt.scl   = 1'b0;
				st_nxt.phase = ST_ADDR_SET;
			end
			ST_STOP_LOW: begin
				st_nxt.sda   = 1'b0;
				st_nxt.phase = ST_STOP_RISE;
			end
			ST_STOP_RISE: begin
				st_nxt.scl   = 1'b1;
				st_nxt.phase = ST_STOP_END;
			end
			ST_STOP_END: begin
				st_nxt.sda   = 1'b1;
				done         = 1'b1;
				st_nxt.phase = ST_IDLE;
			end
			default: begin
				st_nxt.phase = ST_IDLE;
				st_nxt.scl   = 1'b1;
				st_nxt.sda   = 1'b1;
				if (item.kind == KIND_WRITE || item.kind == KIND_READ) begin
					st_nxt.read_mode    = (item.kind == KIND_READ);
					st_nxt.bytes_wanted = item.byte_count;
					st_nxt.bytes_done   = 8'd0;
					st_nxt.shift        = {item.target_address, item.kind == KIND_READ};
					st_nxt.bit_cnt      = 3'd0;
					st_nxt.nack         = 1'b0;
					// start condition: sda falls while scl is high
					st_nxt.sda          = 1'b0;
					st_nxt.phase        = ST_START;
				end
			end
		endcase
	end

	assign busy = (st_nxt.phase != ST_IDLE);

	always_comb begin
		res.scl_out     = st_nxt.scl;
		res.sda_out     = st_nxt.sda;
		res.busy_res    = busy;
		res.done_res    = done;
		res.nacked      = done & st_nxt.nack;
		res.transferred = done ? st_nxt.bytes_done : 8'd0;
		res.rd_data     = rdd;
		res.rd_valid    = rdv;
		res.byte_taken  = taken;
		res.byte_index  = busy ? st_nxt.bytes_done : 8'd0;
	end

endmodule

### rtl/i2cms_out_reg.sv
`timescale 1ns / 1ps
// result register between the sequencer and the master-side stream
// depends on i2cms_pkg

module i2cms_out_reg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  i2cms_pkg::result_t                   res,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [i2cms_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                 free
);
	import i2cms_pkg::*;

	logic    valid_q;
	result_t res_q;

	// free when empty or when the held item leaves this cycle
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_q};

endmodule

### rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// i2c master bit sequencer: state registers, configuration register and result stage
// depends on i2cms_pkg, i2cms_step, i2cms_out_reg
//
// usage
//   each slave-side item is one tick of the bus: tuser carries the kind (tick, begin write,
//   begin read), tdata the address, byte count, next write byte and sampled scl/sda levels.
//   each accepted item yields exactly one master-side item with the line drives and status.
//   begin items while a transaction runs are plain ticks. every bit takes three ticks, plus
//   up to stretch_limit extra ticks while the slave holds scl low.
//   the result of an item is registered and is on m_tdata the cycle after acceptance.
//   throughput is one item per clock while the receiver keeps up, set by the single state
//   update between the input handshake and the result register.
//   when the receiver stalls, the result is held and s_tready drops until it is taken;
//   s_tready stays high in the cycle the held result leaves.
//   cfg_wr_en writes stretch_limit; write it only while no transaction is running.
//   reset puts the bus idle with both lines released, empties the result stage and sets
//   stretch_limit to 101.

module i2c_master_bit_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [7:0]                        cfg_wr_data,   // stretch_limit
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [1:0]                        s_tuser,       // kind
	// target_address[6:0], byte_count[14:7], wr_data[22:15], scl_in[23], sda_in[24]
	input  logic [31:0]                       s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], nacked[4], transferred[12:5],
	// rd_data[20:13], rd_valid[21], byte_taken[22], byte_index[30:23]
	output logic [i2cms_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import i2cms_pkg::*;

	logic       accept;
	logic [7:0] stretch_limit_q;
	seq_state_t st_q, st_nxt;
	item_t      item;
	result_t    res;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		item.kind           = s_tuser;
		item.target_address = s_tdata[6:0];
		item.byte_count     = s_tdata[14:7];
		item.wr_data        = s_tdata[22:15];
		item.scl_in         = s_tdata[23];
		item.sda_in         = s_tdata[24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stretch_limit_q <= STRETCH_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			stretch_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	i2cms_step u_step (
		.st            (st_q),
		.item          (item),
		.stretch_limit (stretch_limit_q),
		.st_nxt        (st_nxt),
		.res           (res)
	);

	i2cms_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.free     (s_tready)
	);

endmodule

### rtl/i2cms_checker.sv
`timescale 1ns / 1ps
// port-level checks for the i2c master bit sequencer, bound to the top level
// depends on i2c_master_bit_sequencer

module i2cms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty result stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty result stage");

	// stop completion leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("busy on done item");

	// nack status only with done
	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3])
		else $error("nacked without done");

	// a tick never both receives a byte and takes a write byte
	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[21] && m_tdata[22]))
		else $error("read and write byte on one item");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
